// ===== sv/bed_pkg.sv =====
`default_nettype none

package bed_pkg;

    // Event codes, one bit each in the enable mask.
    localparam logic [3:0] EV_PRESSED      = 4'd0;
    localparam logic [3:0] EV_RELEASED     = 4'd1;
    localparam logic [3:0] EV_CLICK        = 4'd2;
    localparam logic [3:0] EV_DOUBLE       = 4'd3;
    localparam logic [3:0] EV_TRIPLE       = 4'd4;
    localparam logic [3:0] EV_LONG_START   = 4'd5;
    localparam logic [3:0] EV_LONG_HOLD    = 4'd6;
    localparam logic [3:0] EV_LONG_END     = 4'd7;
    localparam logic [3:0] EV_ULTRA_START  = 4'd8;
    localparam logic [3:0] EV_ULTRA_HOLD   = 4'd9;
    localparam logic [3:0] EV_ULTRA_END    = 4'd10;
    localparam logic [3:0] EV_SEQ_START    = 4'd11;
    localparam logic [3:0] EV_SEQ_COMPLETE = 4'd12;

    // Configuration register indexes.
    localparam logic [2:0] CFG_INVERT       = 3'd0;
    localparam logic [2:0] CFG_DEBOUNCE     = 3'd1;
    localparam logic [2:0] CFG_LONG_TIME    = 3'd2;
    localparam logic [2:0] CFG_ULTRA_TIME   = 3'd3;
    localparam logic [2:0] CFG_CLICK_GAP    = 3'd4;
    localparam logic [2:0] CFG_SEQ_COUNT    = 3'd5;
    localparam logic [2:0] CFG_ADVANCED     = 3'd6;
    localparam logic [2:0] CFG_EVENT_MASK   = 3'd7;

    localparam int MAX_EVENTS = 4;
    localparam int NUM_CAND   = 6;

    typedef struct packed {
        logic        invert_level;
        logic [15:0] debounce_time;
        logic [15:0] long_press_time;
        logic [15:0] ultra_long_press_time;
        logic [15:0] click_gap_time;
        logic [7:0]  sequence_click_count;
        logic        advanced_enable;
        logic [12:0] event_enable_mask;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        invert_level:          1'b1,
        debounce_time:         16'd20,
        long_press_time:       16'd1000,
        ultra_long_press_time: 16'd3000,
        click_gap_time:        16'd300,
        sequence_click_count:  8'd4,
        advanced_enable:       1'b0,
        event_enable_mask:     13'd0
    };

    typedef struct packed {
        logic        primed;
        logic        last_raw;
        logic        stable_level;
        logic [31:0] change_time;
        logic        pressed;
        logic [31:0] press_time;
        logic [31:0] release_time;
        logic        long_flag;
        logic        ultra_flag;
        logic [7:0]  clicks;
    } state_t;

    // All words caused by one sample, ready for serialization.
    typedef struct packed {
        logic                  ev_valid;
        logic [MAX_EVENTS-1:0][3:0] codes;
        logic [2:0]            count;
        logic                  is_pressed;
        logic                  is_long_pressed;
        logic [7:0]            clicks;
        logic [31:0]           hold_ms;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/button_event_detector.sv =====
// Debounced push-button event detector.
//
// Input stream: one word per sample, tdata = {raw_level, timestamp_ms} with the
// millisecond timestamp in bits 31:0 and the raw pin level in bit 32. Output
// stream: one to four words per sample, in event order. tuser is event_valid;
// a sample that fires no enabled event still yields one status-only word with
// tuser low and code zero. tlast marks the final word caused by a sample.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high and writes are expected only while the block is idle.
//
// Each sample is held in the input register, its debounce and event
// logic is evaluated in a single pass into the result register, and its
// first word is then presented on the output. Throughput is set by the
// output serializer: one word per cycle while the receiver keeps tready high.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more sample before tready drops.
// Reset clears the debouncer state so the first sample only primes the level,
// and loads the configuration registers with their default values.
`default_nettype none

module button_event_detector (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [31:0] timestamp_ms, [32] raw_level

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [3:0] event_code, [4] is_pressed,
                                             // [5] is_long_pressed, [13:6] clicks,
                                             // [45:14] hold_ms
    output logic             m_axis_tuser,   // [0] event_valid
    output logic             m_axis_tlast,   // last_of_item

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    bed_pkg::cfg_t    cfg_reg;
    bed_pkg::state_t  state_reg;
    bed_pkg::state_t  state_next;
    bed_pkg::result_t res_reg;
    bed_pkg::result_t res_next;

    logic        in_valid_reg;
    logic [31:0] in_ts_reg;
    logic        in_raw_reg;
    logic        out_valid_reg;
    logic [1:0]  idx_reg;
    logic        out_last;
    logic        out_fire;
    logic        move;

    // Configuration registers; every index names a register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= bed_pkg::CFG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bed_pkg::CFG_INVERT:     cfg_reg.invert_level          <= cfg_data[0];
                bed_pkg::CFG_DEBOUNCE:   cfg_reg.debounce_time         <= cfg_data;
                bed_pkg::CFG_LONG_TIME:  cfg_reg.long_press_time       <= cfg_data;
                bed_pkg::CFG_ULTRA_TIME: cfg_reg.ultra_long_press_time <= cfg_data;
                bed_pkg::CFG_CLICK_GAP:  cfg_reg.click_gap_time        <= cfg_data;
                bed_pkg::CFG_SEQ_COUNT:  cfg_reg.sequence_click_count  <= cfg_data[7:0];
                bed_pkg::CFG_ADVANCED:   cfg_reg.advanced_enable       <= cfg_data[0];
                bed_pkg::CFG_EVENT_MASK: cfg_reg.event_enable_mask     <= cfg_data[12:0];
                default:
                begin
                end
            endcase
        end
    end

    // The result register frees up on the handshake of its last word, so a
    // waiting sample moves forward in that same cycle.
    assign out_last      = ({1'b0, idx_reg} == res_reg.count - 3'd1);
    assign out_fire      = out_valid_reg && m_axis_tready;
    assign move          = in_valid_reg && (!out_valid_reg || (out_fire && out_last));
    assign s_axis_tready = !in_valid_reg || move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_ts_reg  <= s_axis_tdata[31:0];
            in_raw_reg <= s_axis_tdata[32];
        end
    end

    bed_step u_step (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .now     (in_ts_reg),
        .raw     (in_raw_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (move)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (out_fire)
            begin
                if (out_last)
                begin
                    out_valid_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.ev_valid;
    assign m_axis_tlast  = out_last;
    assign m_axis_tdata  = {2'b00, res_reg.hold_ms, res_reg.clicks,
                            res_reg.is_long_pressed, res_reg.is_pressed,
                            res_reg.codes[idx_reg]};

endmodule

`default_nettype wire

// ===== sv/bed_step.sv =====
`default_nettype none

module bed_step (
    input  wire bed_pkg::cfg_t   cfg,
    input  wire bed_pkg::state_t st,
    input  wire logic [31:0]     now,
    input  wire logic            raw,
    output bed_pkg::state_t      st_next,
    output bed_pkg::result_t     res
);

    // Next-state and event logic for one sample.

    logic        lvl;
    logic [31:0] ct;
    logic [31:0] diff_change;
    logic [31:0] diff_press;
    logic [31:0] diff_release;
    logic [31:0] dur1;
    logic [31:0] rel_gap;
    logic        deb_ok;
    logic        press_ev;
    logic        rel_ev;
    logic [7:0]  cnt_press;
    logic [7:0]  cnt1;
    logic        long1;
    logic        ultra1;
    logic        long2;
    logic        ultra2;
    logic        pf1;
    logic [bed_pkg::NUM_CAND-1:0]      cand_en;
    logic [bed_pkg::NUM_CAND-1:0][3:0] cand_code;
    logic [2:0]  n;

    assign lvl          = raw ^ cfg.invert_level;
    assign ct           = (lvl != st.last_raw) ? now : st.change_time;
    assign diff_change  = now - ct;
    assign diff_press   = now - st.press_time;
    assign diff_release = now - st.release_time;

    assign deb_ok   = st.primed && (diff_change >= {16'd0, cfg.debounce_time})
                      && (lvl != st.stable_level);
    assign press_ev = deb_ok && lvl;
    assign rel_ev   = deb_ok && !lvl;

    // A press opens or extends a multi-click run.
    always_comb
    begin
        if (diff_release < {16'd0, cfg.click_gap_time})
        begin
            cnt_press = (st.clicks == 8'hFF) ? 8'hFF : st.clicks + 8'd1;
        end
        else
        begin
            cnt_press = 8'd1;
        end
    end

    assign pf1     = press_ev ? 1'b1 : (rel_ev ? 1'b0 : st.pressed);
    assign cnt1    = press_ev ? cnt_press : st.clicks;
    assign dur1    = press_ev ? 32'd0 : diff_press;
    assign rel_gap = rel_ev ? 32'd0 : diff_release;

    always_comb
    begin
        cand_en   = '0;
        cand_code = '0;
        long1     = st.long_flag;
        ultra1    = st.ultra_flag;

        cand_code[0] = bed_pkg::EV_PRESSED;
        cand_en[0]   = press_ev;
        cand_code[1] = bed_pkg::EV_SEQ_START;
        cand_en[1]   = press_ev && cfg.advanced_enable && (cnt_press == 8'd1);

        if (press_ev)
        begin
            long1  = 1'b0;
            ultra1 = 1'b0;
        end
        else if (rel_ev)
        begin
            // Only one end event: ultra wins over long, long over a plain release.
            if (st.ultra_flag)
            begin
                ultra1       = 1'b0;
                cand_en[2]   = 1'b1;
                cand_code[2] = bed_pkg::EV_ULTRA_END;
            end
            else if (st.long_flag)
            begin
                long1        = 1'b0;
                cand_en[2]   = 1'b1;
                cand_code[2] = bed_pkg::EV_LONG_END;
            end
            else if (diff_press >= {16'd0, cfg.debounce_time})
            begin
                cand_en[2]   = 1'b1;
                cand_code[2] = bed_pkg::EV_RELEASED;
            end
        end

        long2  = long1;
        ultra2 = ultra1;
        if (st.primed && pf1)
        begin
            if (!ultra1 && dur1 >= {16'd0, cfg.ultra_long_press_time})
            begin
                ultra2       = 1'b1;
                cand_en[3]   = 1'b1;
                cand_code[3] = bed_pkg::EV_ULTRA_START;
            end
            else if (!long1 && dur1 >= {16'd0, cfg.long_press_time})
            begin
                long2        = 1'b1;
                cand_en[3]   = 1'b1;
                cand_code[3] = bed_pkg::EV_LONG_START;
            end
            if (ultra2)
            begin
                cand_en[4]   = 1'b1;
                cand_code[4] = bed_pkg::EV_ULTRA_HOLD;
            end
            else if (long2)
            begin
                cand_en[4]   = 1'b1;
                cand_code[4] = bed_pkg::EV_LONG_HOLD;
            end
        end

        st_next.clicks = cnt1;
        if (st.primed && !pf1 && cnt1 != 8'd0 && rel_gap >= {16'd0, cfg.click_gap_time})
        begin
            st_next.clicks = 8'd0;
            cand_en[5]     = 1'b1;
            if (cnt1 == 8'd1)
            begin
                cand_code[5] = bed_pkg::EV_CLICK;
            end
            else if (cnt1 == 8'd2)
            begin
                cand_code[5] = bed_pkg::EV_DOUBLE;
            end
            else if (cnt1 == 8'd3)
            begin
                cand_code[5] = bed_pkg::EV_TRIPLE;
            end
            else if (cnt1 >= cfg.sequence_click_count)
            begin
                cand_code[5] = bed_pkg::EV_SEQ_COMPLETE;
            end
            else
            begin
                // A short run of four or more clicks is dropped silently.
                cand_en[5] = 1'b0;
            end
        end

        // Masked events vanish; the rest are packed in candidate order.
        for (int k = 0; k < bed_pkg::NUM_CAND; k++)
        begin
            cand_en[k] = cand_en[k] && cfg.event_enable_mask[cand_code[k]];
        end

        st_next.primed       = 1'b1;
        st_next.last_raw     = lvl;
        st_next.stable_level = st.primed ? (deb_ok ? lvl : st.stable_level) : lvl;
        st_next.change_time  = st.primed ? ct : now;
        st_next.pressed      = pf1;
        st_next.press_time   = press_ev ? now : st.press_time;
        st_next.release_time = rel_ev ? now : st.release_time;
        st_next.long_flag    = st.primed ? long2 : st.long_flag;
        st_next.ultra_flag   = st.primed ? ultra2 : st.ultra_flag;
    end

    always_comb
    begin
        res       = '0;
        n         = 3'd0;
        for (int k = 0; k < bed_pkg::NUM_CAND; k++)
        begin
            if (cand_en[k] && !n[2])
            begin
                res.codes[n[1:0]] = cand_code[k];
                n = n + 3'd1;
            end
        end
        res.ev_valid        = (n != 3'd0);
        res.count           = (n == 3'd0) ? 3'd1 : n;
        res.is_pressed      = pf1;
        res.is_long_pressed = st_next.long_flag;
        res.clicks          = st_next.clicks;
        res.hold_ms         = pf1 ? dur1 : 32'd0;
    end

endmodule

`default_nettype wire

// ===== sv/bed_checker.sv =====
`default_nettype none

module bed_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // A stalled word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // A status-only word stands alone and carries code zero.
    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[3:0] == 4'd0)
        else $error("status-only word is not a single zero-code word");

    // Event codes stay in range.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3:0] <= bed_pkg::EV_SEQ_COMPLETE)
        else $error("event code out of range");

    // Press duration is reported only while pressed.
    a_dur_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[45:14] == 32'd0)
        else $error("press duration nonzero while released");

endmodule

bind button_event_detector bed_checker u_bed_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

    // Self-checking bench for the button event detector.
    // One word on the input stream is one pin sample. For every accepted sample a
    // behavioral copy of the debouncer, click counter and long-press tracker works
    // out the one to four result words the block must emit. Those words are kept
    // in order and compared against every word taken from the output stream.

    // One pin sample as it travels on the input stream.
    typedef struct packed {
        logic [31:0] ts;
        logic        raw;
    } sample_t;

    // One result word as the block should present it.
    typedef struct packed {
        logic        has_event;
        logic [3:0]  code;
        logic        last_word;
        logic        down;
        logic        long_held;
        logic [7:0]  clicks;
        logic [31:0] down_ms;
    } btn_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    button_event_detector i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Register copies, updated when a configuration write is accepted.
    logic        cfg_al;
    logic [15:0] cfg_db;
    logic [15:0] cfg_long;
    logic [15:0] cfg_ultra;
    logic [15:0] cfg_gap;
    logic [7:0]  cfg_seq;
    logic        cfg_adv;
    logic [12:0] cfg_mask;

    // Button state as the block should hold it.
    logic        primed;
    logic        raw_seen;
    logic        level_db;
    logic [31:0] level_change_ms;
    logic        btn_down;
    logic [31:0] down_ms;
    logic [31:0] up_ms;
    logic        long_on;
    logic        ultra_on;
    logic [7:0]  click_cnt;

    // Events fired by the sample being evaluated, after the mask cut.
    logic [3:0]  fired[8];
    int          n_fired;

    sample_t     samples_todo[$];
    btn_word_t   due_words[$];

    // Handshake flags passed from the rising-edge monitor to the
    // falling-edge drivers; the two never run in the same time step.
    bit          sample_taken;
    bit          word_taken;
    bit          hold_sender;
    bit          no_idle;
    int          send_gap;
    int          recv_stall;

    // Generator view of the current settings, in the units it reasons in.
    logic        g_al;
    int          g_db;
    int          g_lp;
    int          g_ul;
    int          g_gap;
    logic [31:0] now_ms;

    int          n_queued;
    int          n_samples;
    int          n_words;
    int          n_settings;
    int          mismatches;
    logic [15:0] codes_seen;

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 11);
    endfunction

    // An event only leaves the block if its bit in the enable mask is set.
    function automatic void fire(input logic [3:0] code);
        if (cfg_mask[code] && n_fired < 8)
        begin
            fired[n_fired] = code;
            n_fired++;
        end
    endfunction

    // Advance the button state by one sample and queue the result words.
    task automatic compute_events(input logic [31:0] ts, input logic raw);
        logic        lvl;
        logic [31:0] since;
        int          nres;
        btn_word_t   w;
        lvl = cfg_al ? ~raw : raw;
        n_fired = 0;
        if (!primed)
        begin
            // The first sample only seeds the debouncer, even if the button is
            // already held; a press is only seen after a release.
            primed = 1'b1;
            raw_seen = lvl;
            level_db = lvl;
            level_change_ms = ts;
        end
        else
        begin
            if (lvl != raw_seen)
            begin
                level_change_ms = ts;
                raw_seen = lvl;
            end
            since = ts - level_change_ms;
            if (since >= cfg_db && lvl != level_db)
            begin
                level_db = lvl;
                if (lvl)
                begin
                    btn_down = 1'b1;
                    down_ms = ts;
                    long_on = 1'b0;
                    ultra_on = 1'b0;
                    since = ts - up_ms;
                    // Presses inside the gap window extend the multi-click run;
                    // the counter sticks at its top value.
                    if (since < cfg_gap)
                    begin
                        if (click_cnt != 8'd255)
                            click_cnt++;
                    end
                    else
                        click_cnt = 8'd1;
                    fire(bed_pkg::EV_PRESSED);
                    if (cfg_adv && click_cnt == 8'd1)
                        fire(bed_pkg::EV_SEQ_START);
                end
                else
                begin
                    btn_down = 1'b0;
                    up_ms = ts;
                    since = ts - down_ms;
                    if (ultra_on)
                    begin
                        ultra_on = 1'b0;
                        fire(bed_pkg::EV_ULTRA_END);
                    end
                    else if (long_on)
                    begin
                        long_on = 1'b0;
                        fire(bed_pkg::EV_LONG_END);
                    end
                    else if (since >= cfg_db)
                        fire(bed_pkg::EV_RELEASED);
                end
            end
            if (btn_down)
            begin
                since = ts - down_ms;
                if (!ultra_on && since >= cfg_ultra)
                begin
                    ultra_on = 1'b1;
                    fire(bed_pkg::EV_ULTRA_START);
                end
                else if (!long_on && since >= cfg_long)
                begin
                    long_on = 1'b1;
                    fire(bed_pkg::EV_LONG_START);
                end
                if (ultra_on)
                    fire(bed_pkg::EV_ULTRA_HOLD);
                else if (long_on)
                    fire(bed_pkg::EV_LONG_HOLD);
            end
            since = ts - up_ms;
            if (!btn_down && click_cnt != 8'd0 && since >= cfg_gap)
            begin
                // Runs of four or more below the sequence threshold are
                // dropped without an event.
                if (click_cnt == 8'd1)
                    fire(bed_pkg::EV_CLICK);
                else if (click_cnt == 8'd2)
                    fire(bed_pkg::EV_DOUBLE);
                else if (click_cnt == 8'd3)
                    fire(bed_pkg::EV_TRIPLE);
                else if (click_cnt >= cfg_seq)
                    fire(bed_pkg::EV_SEQ_COMPLETE);
                click_cnt = 8'd0;
            end
        end
        // A sample with no enabled event still yields one status word.
        nres = (n_fired > 0) ? n_fired : 1;
        if (nres > bed_pkg::MAX_EVENTS)
            nres = bed_pkg::MAX_EVENTS;
        for (int k = 0; k < nres; k++)
        begin
            w.has_event = (n_fired > 0);
            w.code      = (n_fired > 0) ? fired[k] : 4'd0;
            w.last_word = (k == nres - 1);
            w.down      = btn_down;
            w.long_held = long_on;
            w.clicks    = click_cnt;
            w.down_ms   = btn_down ? ts - down_ms : 32'd0;
            due_words.push_back(w);
        end
    endtask

    // Rising edge: accept configuration writes, predict on every accepted
    // sample and check every word taken from the output stream.
    always @(posedge clk)
    begin : monitor
        btn_word_t w;
        btn_word_t act;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bed_pkg::CFG_INVERT:     cfg_al    = cfg_data[0];
                    bed_pkg::CFG_DEBOUNCE:   cfg_db    = cfg_data;
                    bed_pkg::CFG_LONG_TIME:  cfg_long  = cfg_data;
                    bed_pkg::CFG_ULTRA_TIME: cfg_ultra = cfg_data;
                    bed_pkg::CFG_CLICK_GAP:  cfg_gap   = cfg_data;
                    bed_pkg::CFG_SEQ_COUNT:  cfg_seq   = cfg_data[7:0];
                    bed_pkg::CFG_ADVANCED:   cfg_adv   = cfg_data[0];
                    bed_pkg::CFG_EVENT_MASK: cfg_mask  = cfg_data[12:0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                compute_events(s_axis_tdata[31:0], s_axis_tdata[32]);
                sample_taken = 1'b1;
                n_samples++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                word_taken = 1'b1;
                n_words++;
                act = '{m_axis_tuser, m_axis_tdata[3:0], m_axis_tlast, m_axis_tdata[4],
                        m_axis_tdata[5], m_axis_tdata[13:6], m_axis_tdata[45:14]};
                if (act.has_event)
                    codes_seen[act.code] = 1'b1;
                if (due_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %0d: ev=%0d code=%0d last=%0d",
                                 n_words, act.has_event, act.code, act.last_word);
                end
                else
                begin
                    w = due_words.pop_front();
                    if (act !== w)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("word %0d expected ev=%0d code=%0d last=%0d down=%0d",
                                     n_words, w.has_event, w.code, w.last_word, w.down);
                            $display("    long=%0d clicks=%0d dur=%0d", w.long_held,
                                     w.clicks, w.down_ms);
                            $display("  got ev=%0d code=%0d last=%0d down=%0d long=%0d",
                                     act.has_event, act.code, act.last_word, act.down,
                                     act.long_held);
                            $display("    clicks=%0d dur=%0d", act.clicks, act.down_ms);
                        end
                    end
                end
            end
        end
    end

    // Falling edge: the sample driver. A word is held until accepted, then
    // the sender waits a random number of cycles before offering the next.
    always @(negedge clk)
    begin : sample_driver
        sample_t s;
        logic    nxt;
        if (rst_n)
        begin
            if (!s_axis_tvalid || sample_taken)
            begin
                sample_taken = 1'b0;
                nxt = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (!hold_sender && samples_todo.size() != 0)
                begin
                    s = samples_todo.pop_front();
                    s_axis_tdata <= {7'd0, s.raw, s.ts};
                    nxt = 1'b1;
                    send_gap = draw_wait();
                end
                s_axis_tvalid <= nxt;
            end
        end
    end

    // Falling edge: the result receiver stalls a random number of cycles
    // after each word it takes.
    always @(negedge clk)
    begin : result_sink
        if (rst_n)
        begin
            if (word_taken)
            begin
                word_taken = 1'b0;
                recv_stall = draw_wait();
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic push_raw(input logic [31:0] ts, input logic raw);
        samples_todo.push_back('{ts, raw});
        n_queued++;
    endtask

    // Advance generator time and queue a sample at the given button level.
    task automatic push_sample(input int unsigned dt, input logic pressed);
        now_ms = now_ms + dt;
        push_raw(now_ms, pressed ^ g_al);
    endtask

    // Wait until the block has drained.
    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((samples_todo.size() != 0 || s_axis_tvalid || due_words.size() != 0)
               && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_config(input logic al, input int db, input int lp, input int ul,
                              input int gap, input int sc, input logic adv,
                              input logic [12:0] mask);
        write_reg(bed_pkg::CFG_INVERT, {15'd0, al});
        write_reg(bed_pkg::CFG_DEBOUNCE, db[15:0]);
        write_reg(bed_pkg::CFG_LONG_TIME, lp[15:0]);
        write_reg(bed_pkg::CFG_ULTRA_TIME, ul[15:0]);
        write_reg(bed_pkg::CFG_CLICK_GAP, gap[15:0]);
        write_reg(bed_pkg::CFG_SEQ_COUNT, {8'd0, sc[7:0]});
        write_reg(bed_pkg::CFG_ADVANCED, {15'd0, adv});
        write_reg(bed_pkg::CFG_EVENT_MASK, {3'd0, mask});
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        g_al = al;
        g_db = db;
        g_lp = lp;
        g_ul = ul;
        g_gap = gap;
        n_settings++;
    endtask

    // Small random settings that keep long and ultra presses within reach.
    task automatic random_config();
        int db;
        int lp;
        db = $urandom_range(0, 8);
        lp = $urandom_range(db + 10, 90);
        set_config($urandom_range(0, 1), db, lp, $urandom_range(lp, 200),
                   $urandom_range(10, 80), $urandom_range(0, 8), $urandom_range(0, 1),
                   $urandom_range(0, 8191));
    endtask

    // One press with contact bounce on both edges, then idle time released.
    task automatic gen_press(input int hold, input int after, input int step_max);
        int nb;
        int i;
        int t;
        int d;
        nb = $urandom_range(0, 3);
        for (i = 0; i < nb; i++)
            push_sample($urandom_range(0, 2), ~i[0]);
        t = 0;
        while (t < hold)
        begin
            d = $urandom_range(1, step_max);
            push_sample(d, 1'b1);
            t += d;
        end
        nb = $urandom_range(0, 3);
        for (i = 0; i < nb; i++)
            push_sample($urandom_range(0, 2), i[0]);
        t = 0;
        while (t < after)
        begin
            d = $urandom_range(1, step_max);
            push_sample(d, 1'b0);
            t += d;
        end
    endtask

    // Mostly well-formed gestures: click runs, long and ultra presses; the
    // rest are glitches no longer than the debounce time and timestamp jumps.
    task automatic gen_gesture(input int step_max);
        int kind;
        int n;
        int i;
        int idle;
        kind = $urandom_range(0, 11);
        if (kind <= 5)
        begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                if (i == n - 1)
                    idle = g_gap + $urandom_range(1, 3 * step_max);
                else
                    idle = $urandom_range(g_db + 1, g_db + 1 + g_gap / 2);
                gen_press(g_db + $urandom_range(1, 3 * step_max), idle, step_max);
            end
        end
        else if (kind <= 7)
            gen_press(g_db + $urandom_range(g_lp, g_ul), g_gap + step_max, step_max);
        else if (kind == 8)
            gen_press(g_db + g_ul + $urandom_range(1, 4 * step_max), g_gap + step_max,
                      step_max);
        else if (kind == 9)
        begin
            push_sample(1, 1'b1);
            push_sample($urandom_range(0, g_db), 1'b0);
            push_sample($urandom_range(1, step_max), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                now_ms = $urandom;
                push_raw(now_ms, $urandom_range(0, 1));
            end
        end
    endtask

    initial
    begin
        int target;
        int half;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cfg_al = 1'b1;
        cfg_db = 16'd20;
        cfg_long = 16'd1000;
        cfg_ultra = 16'd3000;
        cfg_gap = 16'd300;
        cfg_seq = 8'd4;
        cfg_adv = 1'b0;
        cfg_mask = '0;
        primed = 1'b0;
        raw_seen = 1'b0;
        level_db = 1'b0;
        level_change_ms = '0;
        btn_down = 1'b0;
        down_ms = '0;
        up_ms = '0;
        long_on = 1'b0;
        ultra_on = 1'b0;
        click_cnt = '0;
        sample_taken = 1'b0;
        word_taken = 1'b0;
        hold_sender = 1'b0;
        no_idle = 1'b0;
        send_gap = 0;
        recv_stall = 0;
        g_al = 1'b1;
        g_db = 20;
        g_lp = 1000;
        g_ul = 3000;
        g_gap = 300;
        now_ms = '0;
        n_queued = 0;
        n_samples = 0;
        n_words = 0;
        n_settings = 0;
        mismatches = 0;
        codes_seen = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings with every event masked off; the first sample primes
        // the debouncer while the button is already held down.
        push_raw(32'd1000, 1'b0);
        push_raw(32'd1030, 1'b0);
        wait_idle();
        write_reg(bed_pkg::CFG_EVENT_MASK, 16'h1FFF);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        push_raw(32'd1040, 1'b1);
        push_raw(32'd1070, 1'b1);
        push_raw(32'd1100, 1'b0);
        push_raw(32'd1125, 1'b0);
        push_raw(32'd1200, 1'b1);
        push_raw(32'd1230, 1'b1);
        push_raw(32'd1600, 1'b1);
        wait_idle();

        // All thresholds zero: a press fires four events at once, and the
        // timestamps cross the 32-bit wrap.
        set_config(1'b0, 0, 0, 0, 0, 0, 1'b1, 13'h1FFF);
        push_raw(32'hFFFF_FFFF, 1'b1);
        push_raw(32'd0, 1'b1);
        push_raw(32'd5, 1'b0);
        push_raw(32'd6, 1'b1);
        push_raw(32'd7, 1'b0);
        wait_idle();

        // All thresholds at their top values.
        set_config(1'b1, 65535, 65535, 65535, 65535, 255, 1'b0, 13'h1FFF);
        push_raw(32'd0, 1'b1);
        push_raw(32'd10, 1'b0);
        push_raw(32'd65545, 1'b0);
        push_raw(32'd131080, 1'b0);
        push_raw(32'h8000_0000, 1'b1);
        push_raw(32'h8000_FFFF, 1'b1);
        push_raw(32'hFFFF_0000, 1'b1);
        wait_idle();

        // Well-formed gestures; halfway through the sender holds back until
        // every outstanding word has come out.
        set_config(1'b1, 5, 60, 150, 40, 4, 1'b1, 13'h1FFF);
        now_ms = 32'd5000;
        target = n_queued + 85;
        while (n_queued < target)
            gen_gesture(12);
        half = samples_todo.size() / 2;
        while (samples_todo.size() > half)
            @(posedge clk);
        hold_sender = 1'b1;
        while (s_axis_tvalid || due_words.size() != 0)
            @(negedge clk);
        @(posedge clk);
        hold_sender = 1'b0;
        wait_idle();

        // Random settings and mask, with time running across the wrap.
        random_config();
        now_ms = 32'hFFFF_FF00;
        target = n_queued + 85;
        while (n_queued < target)
            gen_gesture(10);
        wait_idle();

        // Noise-heavy stretch with neither side idling.
        random_config();
        no_idle = 1'b1;
        target = n_queued + 50;
        while (n_queued < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                now_ms = $urandom;
                push_raw(now_ms, $urandom_range(0, 1));
            end
            else
                gen_gesture(8);
        end
        wait_idle();
        no_idle = 1'b0;

        // A fast run of many clicks, then a long pause so the run completes
        // as a sequence.
        set_config($urandom_range(0, 1), 0, 65535, 65535, 65535, 30, 1'b1, 13'h1FFF);
        repeat (40)
        begin
            push_sample(1, 1'b1);
            push_sample(1, 1'b0);
        end
        push_sample(70000, 1'b0);
        wait_idle();

        random_config();
        target = n_queued + 65;
        while (n_queued < target)
            gen_gesture(10);
        wait_idle();

        repeat (20) @(posedge clk);
        if (due_words.size() != 0)
        begin
            $display("%0d expected words never arrived", due_words.size());
            mismatches += due_words.size();
        end
        $display("Run covered %0d samples, %0d result words, %0d register settings.",
                 n_samples, n_words, n_settings);
        $display("Event codes observed (bit per code): %b, mismatches: %0d",
                 codes_seen[12:0], mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
